// ----- hw/rtl/kfrf_pkg.sv -----
// kfrf_pkg: shared types and constants for the keyframe redundancy filter.
// No dependencies; imported by the interfaces and every kfrf module.
`timescale 1ns / 1ps
`default_nettype none
package kfrf_pkg;

  localparam int unsigned TIME_W      = 32;
  localparam int unsigned FIELD_W     = 32;
  localparam int unsigned COUNT_W     = 3;
  localparam int unsigned THRESH_W    = 31;
  localparam int unsigned CFG_DATA_W  = 31;
  localparam int unsigned CFG_INDEX_W = 2;
  localparam int unsigned DEF_COMP_W  = 32;
  localparam int unsigned QUEUE_DEPTH = 4;

  localparam logic [COUNT_W-1:0]  COUNT_RESET  = COUNT_W'(4);
  localparam logic [COUNT_W-1:0]  COUNT_QUAT   = COUNT_W'(4);
  localparam logic [THRESH_W-1:0] THRESH_RESET = THRESH_W'(7);

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_COMP_COUNT = 2'd0,
    CFG_THRESHOLD  = 2'd1
  } cfg_index_t;

  typedef struct packed {
    logic        [TIME_W-1:0]  key_time;
    logic signed [FIELD_W-1:0] x;
    logic signed [FIELD_W-1:0] y;
    logic signed [FIELD_W-1:0] z;
    logic signed [FIELD_W-1:0] w;
  } key_t;

  // One queued command: optional held-back previous key, then the current key.
  typedef struct packed {
    key_t prev_key;
    key_t cur_key;
    logic emit_prev;
    logic last;
  } cmd_t;

endpackage
`default_nettype wire

// ----- hw/rtl/kfrf_if.sv -----
// kfrf_key_if and kfrf_result_if: valid/ready channels for keys and results.
// Depends on kfrf_pkg.
`timescale 1ns / 1ps
`default_nettype none
interface kfrf_key_if;
  import kfrf_pkg::*;
  logic                      valid;
  logic                      ready;
  logic        [TIME_W-1:0]  key_time;
  logic signed [FIELD_W-1:0] comp_x;
  logic signed [FIELD_W-1:0] comp_y;
  logic signed [FIELD_W-1:0] comp_z;
  logic signed [FIELD_W-1:0] comp_w;
  logic                      first_key;
  logic                      last_key;
  modport source (output valid, key_time, comp_x, comp_y, comp_z, comp_w, first_key,
                  last_key, input ready);
  modport sink (input valid, key_time, comp_x, comp_y, comp_z, comp_w, first_key,
                last_key, output ready);
endinterface

interface kfrf_result_if;
  import kfrf_pkg::*;
  logic                      valid;
  logic                      ready;
  logic        [TIME_W-1:0]  out_time;
  logic signed [FIELD_W-1:0] out_x;
  logic signed [FIELD_W-1:0] out_y;
  logic signed [FIELD_W-1:0] out_z;
  logic signed [FIELD_W-1:0] out_w;
  logic                      run_end;
  logic                      track_end;
  modport source (output valid, out_time, out_x, out_y, out_z, out_w, run_end, track_end,
                  input ready);
  modport sink (input valid, out_time, out_x, out_y, out_z, out_w, run_end, track_end,
                output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/kfrf_front.sv -----
// kfrf_front: configuration registers, key classification and filter state.
// Depends on kfrf_pkg and kfrf_key_if; pushes commands toward kfrf_queue.
`timescale 1ns / 1ps
`default_nettype none
module kfrf_front #(
  parameter int unsigned COMP_WIDTH = kfrf_pkg::DEF_COMP_W
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  kfrf_key_if.sink                             keys,
  input  wire logic                            cfg_we,
  input  wire logic [kfrf_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [kfrf_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  wire logic                            push_ready,
  output logic                                 push,
  output kfrf_pkg::cmd_t                       push_cmd
);
  import kfrf_pkg::*;

  localparam int unsigned DIFF_W = COMP_WIDTH + 1;
  localparam int unsigned CMP_W  = (DIFF_W > THRESH_W) ? DIFF_W : THRESH_W;

  logic [COUNT_W-1:0]  comp_count;
  logic [THRESH_W-1:0] threshold;

  logic [TIME_W-1:0]     emitted_time;
  logic [COMP_WIDTH-1:0] emitted_val [4];
  key_t                  previous;

  logic [FIELD_W-1:0]    raw     [4];
  logic [COMP_WIDTH-1:0] cur_cw  [4];
  logic [FIELD_W-1:0]    cur_out [4];
  logic [3:0]            lane_over;

  logic accept, four, changed, time_new, emit_prev, emit_cur;
  key_t cur_key, prev_key;

  assign raw[0] = keys.comp_x;
  assign raw[1] = keys.comp_y;
  assign raw[2] = keys.comp_z;
  assign raw[3] = keys.comp_w;

  for (genvar i = 0; i < 4; i++) begin : g_lane
    logic signed [DIFF_W-1:0] diff;
    logic        [DIFF_W-1:0] mag;
    if (COMP_WIDTH <= FIELD_W) begin : g_narrow
      assign cur_cw[i] = raw[i][COMP_WIDTH-1:0];
      assign cur_out[i] = FIELD_W'(signed'(raw[i][COMP_WIDTH-1:0]));
    end else begin : g_wide
      assign cur_cw[i] = COMP_WIDTH'(raw[i]);
      assign cur_out[i] = raw[i];
    end
    assign diff = signed'({emitted_val[i][COMP_WIDTH-1], emitted_val[i]})
                - signed'({cur_cw[i][COMP_WIDTH-1], cur_cw[i]});
    assign mag = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
    assign lane_over[i] = CMP_W'(mag) > CMP_W'(threshold);
  end

  always_comb begin
    accept    = keys.valid & keys.ready;
    four      = comp_count >= COUNT_QUAT;
    changed   = lane_over[0] | lane_over[1] | lane_over[2] | (four & lane_over[3]);
    time_new  = emitted_time != keys.key_time;
    emit_prev = !keys.first_key & changed & (emitted_time != previous.key_time);
    emit_cur  = keys.first_key | changed | (keys.last_key & time_new);

    cur_key.key_time = keys.key_time;
    cur_key.x        = cur_out[0];
    cur_key.y        = cur_out[1];
    cur_key.z        = cur_out[2];
    cur_key.w        = four ? cur_out[3] : '0;
    prev_key         = previous;
    if (!four) begin
      prev_key.w = '0;
    end

    push_cmd.prev_key  = prev_key;
    push_cmd.cur_key   = cur_key;
    push_cmd.emit_prev = emit_prev;
    push_cmd.last      = keys.last_key;
    push               = accept & emit_cur;
  end

  assign keys.ready = push_ready & !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      comp_count   <= COUNT_RESET;
      threshold    <= THRESH_RESET;
      emitted_time <= '0;
      previous     <= '0;
      for (int i = 0; i < 4; i++) begin
        emitted_val[i] <= '0;
      end
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_COMP_COUNT: comp_count <= cfg_data[COUNT_W-1:0];
          CFG_THRESHOLD:  threshold  <= cfg_data[THRESH_W-1:0];
          default: ;
        endcase
      end
      if (accept) begin
        previous.key_time <= keys.key_time;
        previous.x        <= cur_out[0];
        previous.y        <= cur_out[1];
        previous.z        <= cur_out[2];
        previous.w        <= cur_out[3];
        if (emit_cur) begin
          emitted_time <= keys.key_time;
          for (int i = 0; i < 4; i++) begin
            emitted_val[i] <= cur_cw[i];
          end
        end
      end
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/kfrf_queue.sv -----
// kfrf_queue: small command FIFO between the classifying front and emitting back.
// Depends on kfrf_pkg.
`timescale 1ns / 1ps
`default_nettype none
module kfrf_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire kfrf_pkg::cmd_t push_cmd,
  output logic                push_ready,
  input  wire logic           pop,
  output logic                head_valid,
  output kfrf_pkg::cmd_t      head_cmd
);
  import kfrf_pkg::*;

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t             slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;

  assign push_ready = count != CNT_W'(QUEUE_DEPTH);
  assign head_valid = count != '0;
  assign head_cmd   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/kfrf_back.sv -----
// kfrf_back: expands each queued command into one or two result transfers.
// Depends on kfrf_pkg and kfrf_result_if; reads the head of kfrf_queue.
`timescale 1ns / 1ps
`default_nettype none
module kfrf_back (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           head_valid,
  input  wire kfrf_pkg::cmd_t head_cmd,
  output logic                pop,
  kfrf_result_if.source       results
);
  import kfrf_pkg::*;

  logic prev_done;
  logic show_prev, xfer;
  key_t sel;

  always_comb begin
    show_prev         = head_cmd.emit_prev & !prev_done;
    sel               = show_prev ? head_cmd.prev_key : head_cmd.cur_key;
    results.valid     = head_valid;
    results.out_time  = sel.key_time;
    results.out_x     = sel.x;
    results.out_y     = sel.y;
    results.out_z     = sel.z;
    results.out_w     = sel.w;
    results.run_end   = !show_prev;
    results.track_end = !show_prev & head_cmd.last;
    xfer              = head_valid & results.ready;
    pop               = xfer & !show_prev;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_done <= 1'b0;
    end else if (xfer) begin
      prev_done <= show_prev;
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/keyframe_redundancy_filter.sv -----
// keyframe_redundancy_filter: top level; front classifier, command queue, back emitter.
// Depends on kfrf_pkg, kfrf_if, kfrf_front, kfrf_queue and kfrf_back.
//
//   channel   dir  handshake        payload
//   keys      in   valid/ready      key_time, comp_x..comp_w, first_key, last_key
//   results   out  valid/ready      out_time, out_x..out_w, run_end, track_end
//   cfg       in   cfg_we only      cfg_index, cfg_data
//
// A key is classified in the cycle it is accepted; one new key per cycle while
// the 4-entry command queue has room. The back emits one result per cycle while results
// are ready, so a key that yields two results occupies it for two transfers.
// Synchronous reset empties the queue, resets config to defaults, clears state.
`timescale 1ns / 1ps
`default_nettype none
module keyframe_redundancy_filter #(
  parameter int unsigned COMP_WIDTH = kfrf_pkg::DEF_COMP_W
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  kfrf_key_if.sink                              keys,
  kfrf_result_if.source                         results,
  input  wire logic                             cfg_we,
  input  wire logic [kfrf_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [kfrf_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import kfrf_pkg::*;

  logic push, push_ready, pop, head_valid;
  cmd_t push_cmd, head_cmd;

  kfrf_front #(
    .COMP_WIDTH (COMP_WIDTH)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .keys       (keys),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .push_ready (push_ready),
    .push       (push),
    .push_cmd   (push_cmd)
  );

  kfrf_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_cmd   (push_cmd),
    .push_ready (push_ready),
    .pop        (pop),
    .head_valid (head_valid),
    .head_cmd   (head_cmd)
  );

  kfrf_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_cmd   (head_cmd),
    .pop        (pop),
    .results    (results)
  );

endmodule
`default_nettype wire
